@@ rtl/core/wps_pkg.sv @@
// ----------------------------------------------------------------------------
// wps_pkg: shared constants for the waypoint path stepper
// Request and status codes, register indexes and the iteration counts of
// the bit-serial square root and divider.
// ----------------------------------------------------------------------------
package wps_pkg;

    localparam int MAX_POINTS = 16;
    localparam int IDX_W      = $clog2(MAX_POINTS);

    // request kinds carried in s_tuser
    localparam logic [1:0] REQ_LOAD  = 2'd0;
    localparam logic [1:0] REQ_START = 2'd1;
    localparam logic [1:0] REQ_TICK  = 2'd2;

    // result status carried in m_tuser
    localparam logic [1:0] ST_NONE   = 2'd0;
    localparam logic [1:0] ST_STEP   = 2'd1;
    localparam logic [1:0] ST_ARRIVE = 2'd2;
    localparam logic [1:0] ST_LOADED = 2'd3;

    // register indexes (byte address / 4)
    localparam logic [2:0] REG_MOVE_EN = 3'd0;
    localparam logic [2:0] REG_LOOP    = 3'd1;
    localparam logic [2:0] REG_FACE    = 3'd2;
    localparam logic [2:0] REG_SPEED   = 3'd3;
    localparam logic [2:0] REG_NPTS    = 3'd4;

    // one root bit per cycle, one quotient bit per cycle
    localparam int SQRT_STEPS = 32;
    localparam int DIV_STEPS  = 25;

endpackage

@@ rtl/core/waypoint_path_stepper_unit.sv @@
// ----------------------------------------------------------------------------
// waypoint_path_stepper_unit: constant-speed waypoint path follower
// Keeps a waypoint table, a position and a target index, and steps the
// position toward the target on tick items.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel takes one request item: s_tuser holds the kind (load a
//   waypoint, start at waypoint 0, time tick), s_tdata the slot, the point
//   and the tick length. m_ channel returns exactly one result item per
//   request: position, direction, target slot, and status in m_tuser.
//   The APB port sets enable, loop, facing, speed and point count; write it
//   only while no request is in flight.
//   A load, start or idle tick does no arithmetic. A tick that steps passes
//   through the shared 32x32 multiplier, the bit-serial square root (one
//   root bit per cycle) and six parallel bit-serial dividers; an arriving
//   tick stops before the square root. One request is in work at a time;
//   the next is taken as soon as the previous result sits in the output
//   register.
//   Reset clears position, target index and registers; the waypoint table
//   holds nothing valid until loaded. When the receiver stalls, the result
//   is held in the output register and a finished next result waits for it.
// ----------------------------------------------------------------------------
module waypoint_path_stepper_unit (
    input  logic         aclk,
    input  logic         aresetn,
    // request channel
    input  logic         s_tvalid,
    output logic         s_tready,
    // point_index[3:0], point_x[35:4], point_y[67:36], point_z[99:68],
    // delta_time[115:100], zero pad
    input  logic [119:0] s_tdata,
    // req_type[1:0]
    input  logic [1:0]   s_tuser,
    // result channel
    output logic         m_tvalid,
    input  logic         m_tready,
    // pos_x[31:0], pos_y[63:32], pos_z[95:64], dir_x[111:96], dir_y[127:112],
    // dir_z[143:128], dir_valid[144], target_slot[149:145], zero pad
    output logic [151:0] m_tdata,
    // status[1:0]
    output logic [1:0]   m_tuser,
    // configuration
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    typedef enum logic [3:0] {
        S_IDLE, S_READ, S_USE, S_MUL, S_SUM, S_DECIDE,
        S_SQRT, S_DINIT, S_DIV, S_APPLY, S_FIN
    } state_t;

    localparam logic [4:0] MAX5 = 5'(wps_pkg::MAX_POINTS);

    state_t      state_reg;

    // configuration registers
    logic        move_en_reg, loop_reg, face_reg;
    logic [23:0] speed_reg;
    logic [4:0]  npts_reg;

    // waypoint table
    logic [95:0] mem [wps_pkg::MAX_POINTS];
    logic [wps_pkg::IDX_W-1:0] rd_addr_reg;
    logic [95:0] rd_data_reg;

    // path state and work registers
    logic [1:0]  req_reg;
    logic [31:0] pos_reg [3];
    logic [4:0]  tgt_reg;
    logic [23:0] step_reg;
    logic [2:0]  neg_reg;
    logic [31:0] b_reg [3];
    logic        small_reg;
    logic [63:0] sqv_reg [3];
    logic [47:0] thr2_reg;
    logic [55:0] nm_reg [3];
    logic [63:0] sq_reg;
    logic [5:0]  cnt_reg;
    logic [63:0] rad_reg;
    logic [32:0] srem_reg;
    logic [31:0] root_reg;
    logic [31:0] dist_reg;
    logic [31:0] drem_reg [6];
    logic [24:0] dlow_reg [6];
    logic [24:0] quo_reg [6];
    logic [15:0] dir_reg [3];
    logic        dv_reg;
    logic [1:0]  status_reg;

    // output register
    logic         m_tvalid_reg;
    logic [151:0] m_tdata_reg;
    logic [1:0]   m_tuser_reg;

    logic [4:0]  n_pts;
    logic        accept;
    logic        cfg_wr;
    logic [23:0] thr;
    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_p;
    logic [31:0] a_abs [3];
    logic [2:0]  a_neg;
    logic [31:0] m_max;
    logic [34:0] sq_rm, sq_trial;
    logic [32:0] dv_t [6];
    logic [4:0]  tgt_inc;

    assign n_pts    = (npts_reg > MAX5) ? MAX5 : npts_reg;
    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign cfg_wr   = psel && penable && pwrite;
    assign pready   = 1'b1;
    assign thr      = (step_reg > 24'd256) ? step_reg : 24'd256;
    assign tgt_inc  = tgt_reg + 5'd1;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // register readback
    always_comb begin
        prdata = '0;
        case (paddr[4:2])
            wps_pkg::REG_MOVE_EN: prdata = {31'd0, move_en_reg};
            wps_pkg::REG_LOOP:    prdata = {31'd0, loop_reg};
            wps_pkg::REG_FACE:    prdata = {31'd0, face_reg};
            wps_pkg::REG_SPEED:   prdata = {8'd0, speed_reg};
            wps_pkg::REG_NPTS:    prdata = {27'd0, npts_reg};
            default:              prdata = '0;
        endcase
    end

    // difference magnitudes toward the target
    always_comb begin
        logic [32:0] df;
        m_max = '0;
        for (int i = 0; i < 3; i++) begin
            df = {rd_data_reg[32*i+31], rd_data_reg[32*i +: 32]}
               - {pos_reg[i][31], pos_reg[i]};
            a_neg[i] = df[32];
            a_abs[i] = df[32] ? 32'(-df) : df[31:0];
            if (a_abs[i] > m_max) m_max = a_abs[i];
        end
    end

    // shared multiplier operand select
    always_comb begin
        mul_a = b_reg[0];
        mul_b = b_reg[0];
        case (cnt_reg)
            6'd0: begin mul_a = b_reg[0]; mul_b = b_reg[0]; end
            6'd1: begin mul_a = b_reg[1]; mul_b = b_reg[1]; end
            6'd2: begin mul_a = b_reg[2]; mul_b = b_reg[2]; end
            6'd3: begin mul_a = {8'd0, thr}; mul_b = {8'd0, thr}; end
            6'd4: begin mul_a = b_reg[0]; mul_b = {8'd0, step_reg}; end
            6'd5: begin mul_a = b_reg[1]; mul_b = {8'd0, step_reg}; end
            default: begin mul_a = b_reg[2]; mul_b = {8'd0, step_reg}; end
        endcase
        mul_p = mul_a * mul_b;
    end

    // one square root digit and one quotient bit per lane
    assign sq_rm    = {srem_reg, rad_reg[63:62]};
    assign sq_trial = {1'b0, root_reg, 2'b01};
    always_comb begin
        for (int k = 0; k < 6; k++)
            dv_t[k] = {drem_reg[k], dlow_reg[k][24]};
    end

    // waypoint table write and registered read
    always_ff @(posedge aclk) begin
        if (accept && s_tuser == wps_pkg::REQ_LOAD
            && {1'b0, s_tdata[3:0]} < 5'(wps_pkg::MAX_POINTS))
            mem[s_tdata[wps_pkg::IDX_W-1:0]] <= s_tdata[99:4];
        if (state_reg == S_READ)
            rd_data_reg <= mem[rd_addr_reg];
    end

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            move_en_reg <= 1'b0;
            loop_reg    <= 1'b0;
            face_reg    <= 1'b0;
            speed_reg   <= '0;
            npts_reg    <= '0;
        end else if (cfg_wr) begin
            case (paddr[4:2])
                wps_pkg::REG_MOVE_EN: move_en_reg <= pwdata[0];
                wps_pkg::REG_LOOP:    loop_reg    <= pwdata[0];
                wps_pkg::REG_FACE:    face_reg    <= pwdata[0];
                wps_pkg::REG_SPEED:   speed_reg   <= pwdata[23:0];
                wps_pkg::REG_NPTS:    npts_reg    <= pwdata[4:0];
                default: ;
            endcase
        end
    end

    // sequencer: state, path state and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
            tgt_reg      <= '0;
            cnt_reg      <= '0;
            for (int i = 0; i < 3; i++) pos_reg[i] <= '0;
        end else begin
            if (m_tready && state_reg != S_FIN) m_tvalid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        req_reg    <= s_tuser;
                        dv_reg     <= 1'b0;
                        for (int i = 0; i < 3; i++) dir_reg[i] <= '0;
                        step_reg   <= 24'(({24'd0, speed_reg} * {32'd0, s_tdata[115:100]})
                                          >> 16);
                        case (s_tuser)
                            wps_pkg::REQ_LOAD: begin
                                status_reg <= ({1'b0, s_tdata[3:0]}
                                               < 5'(wps_pkg::MAX_POINTS))
                                              ? wps_pkg::ST_LOADED : wps_pkg::ST_NONE;
                                state_reg  <= S_FIN;
                            end
                            wps_pkg::REQ_START: begin
                                status_reg <= wps_pkg::ST_NONE;
                                if (n_pts != 5'd0) begin
                                    rd_addr_reg <= '0;
                                    state_reg   <= S_READ;
                                end else begin
                                    state_reg   <= S_FIN;
                                end
                            end
                            wps_pkg::REQ_TICK: begin
                                status_reg <= wps_pkg::ST_NONE;
                                if (move_en_reg && n_pts >= 5'd2 && speed_reg != 24'd0
                                    && (tgt_reg < n_pts || loop_reg)) begin
                                    state_reg <= S_READ;
                                    // wrap a finished path back to the first point
                                    if (tgt_reg >= n_pts) begin
                                        tgt_reg     <= '0;
                                        rd_addr_reg <= '0;
                                    end else begin
                                        rd_addr_reg <= tgt_reg[wps_pkg::IDX_W-1:0];
                                    end
                                end else begin
                                    state_reg <= S_FIN;
                                end
                            end
                            default: begin
                                status_reg <= wps_pkg::ST_NONE;
                                state_reg  <= S_FIN;
                            end
                        endcase
                    end
                end
                S_READ: state_reg <= S_USE;
                S_USE: begin
                    if (req_reg == wps_pkg::REQ_START) begin
                        for (int i = 0; i < 3; i++) pos_reg[i] <= rd_data_reg[32*i +: 32];
                        tgt_reg    <= (n_pts > 5'd1) ? 5'd1 : 5'd0;
                        status_reg <= wps_pkg::ST_LOADED;
                        state_reg  <= S_FIN;
                    end else begin
                        // halve all magnitudes when any reaches 2^31
                        for (int i = 0; i < 3; i++)
                            b_reg[i] <= m_max[31] ? (a_abs[i] >> 1) : a_abs[i];
                        neg_reg   <= a_neg;
                        small_reg <= (m_max[31:24] == 8'd0);
                        cnt_reg   <= '0;
                        state_reg <= S_MUL;
                    end
                end
                S_MUL: begin
                    case (cnt_reg)
                        6'd0: sqv_reg[0] <= mul_p;
                        6'd1: sqv_reg[1] <= mul_p;
                        6'd2: sqv_reg[2] <= mul_p;
                        6'd3: thr2_reg   <= mul_p[47:0];
                        6'd4: nm_reg[0]  <= mul_p[55:0];
                        6'd5: nm_reg[1]  <= mul_p[55:0];
                        default: nm_reg[2] <= mul_p[55:0];
                    endcase
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'd6) state_reg <= S_SUM;
                end
                S_SUM: begin
                    sq_reg    <= sqv_reg[0] + sqv_reg[1] + sqv_reg[2];
                    state_reg <= S_DECIDE;
                end
                S_DECIDE: begin
                    if (small_reg && sq_reg <= {16'd0, thr2_reg}) begin
                        // snap to target and advance
                        for (int i = 0; i < 3; i++) pos_reg[i] <= rd_data_reg[32*i +: 32];
                        if (tgt_inc >= n_pts) tgt_reg <= loop_reg ? 5'd0 : n_pts;
                        else                  tgt_reg <= tgt_inc;
                        status_reg <= wps_pkg::ST_ARRIVE;
                        state_reg  <= S_FIN;
                    end else begin
                        rad_reg   <= sq_reg;
                        srem_reg  <= '0;
                        root_reg  <= '0;
                        cnt_reg   <= '0;
                        state_reg <= S_SQRT;
                    end
                end
                S_SQRT: begin
                    if (sq_rm >= sq_trial) begin
                        srem_reg <= 33'(sq_rm - sq_trial);
                        root_reg <= {root_reg[30:0], 1'b1};
                    end else begin
                        srem_reg <= sq_rm[32:0];
                        root_reg <= {root_reg[30:0], 1'b0};
                    end
                    rad_reg <= {rad_reg[61:0], 2'b00};
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'(wps_pkg::SQRT_STEPS - 1)) state_reg <= S_DINIT;
                end
                S_DINIT: begin
                    dist_reg <= (root_reg == 32'd0) ? 32'd1 : root_reg;
                    for (int i = 0; i < 3; i++) begin
                        drem_reg[i]   <= {1'b0, nm_reg[i][55:25]};
                        dlow_reg[i]   <= nm_reg[i][24:0];
                        drem_reg[i+3] <= {12'd0, b_reg[i][30:11]};
                        dlow_reg[i+3] <= {b_reg[i][10:0], 14'd0};
                    end
                    for (int k = 0; k < 6; k++) quo_reg[k] <= '0;
                    cnt_reg   <= '0;
                    state_reg <= S_DIV;
                end
                S_DIV: begin
                    for (int k = 0; k < 6; k++) begin
                        if (dv_t[k] >= {1'b0, dist_reg}) begin
                            drem_reg[k] <= 32'(dv_t[k] - {1'b0, dist_reg});
                            quo_reg[k]  <= {quo_reg[k][23:0], 1'b1};
                        end else begin
                            drem_reg[k] <= dv_t[k][31:0];
                            quo_reg[k]  <= {quo_reg[k][23:0], 1'b0};
                        end
                        dlow_reg[k] <= {dlow_reg[k][23:0], 1'b0};
                    end
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'(wps_pkg::DIV_STEPS - 1)) state_reg <= S_APPLY;
                end
                S_APPLY: begin
                    for (int i = 0; i < 3; i++) begin
                        if (neg_reg[i]) pos_reg[i] <= pos_reg[i] - {7'd0, quo_reg[i]};
                        else            pos_reg[i] <= pos_reg[i] + {7'd0, quo_reg[i]};
                        if (face_reg)
                            dir_reg[i] <= neg_reg[i] ? 16'(-quo_reg[i+3]) : quo_reg[i+3][15:0];
                    end
                    dv_reg     <= face_reg;
                    status_reg <= wps_pkg::ST_STEP;
                    state_reg  <= S_FIN;
                end
                S_FIN: begin
                    // hand over once the output register is free
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {2'b00, tgt_reg, dv_reg, dir_reg[2], dir_reg[1],
                                         dir_reg[0], pos_reg[2], pos_reg[1], pos_reg[0]};
                        m_tuser_reg  <= status_reg;
                        state_reg    <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // a stepping result carries the facing flag, nothing else does
    a_step_dir: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_FIN && status_reg != wps_pkg::ST_STEP |-> !dv_reg)
        else $error("direction flagged on a result that did not step");

    // a result is not overwritten while the receiver stalls
    a_hold_out: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && !m_tready |=> m_tvalid_reg && $stable(m_tdata_reg))
        else $error("pending result lost");

    // the divider never starts with a zero divisor
    a_dist_nz: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_DIV |-> dist_reg != 32'd0)
        else $error("zero divisor in divider");

endmodule
